### hdl/ir_pulse_width_code_decoder_macros.svh
// ----------------------------------------------------------------------------
// ir pulse width code decoder assertion macros
// shared concurrent assertion wrappers, clocked on clock
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_CODE_DECODER_MACROS_SVH
`define IR_PULSE_WIDTH_CODE_DECODER_MACROS_SVH

// check that is switched off while reset is high
`define IRPW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also runs through reset
`define IRPW_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/ir_pwcd_pkg.sv
// ----------------------------------------------------------------------------
// ir_pwcd_pkg
// types, register map and helpers shared by the ir pulse width code decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ir_pwcd_pkg;

   localparam int TimeWidth  = 16;
   localparam int CodeWidth  = 12;
   localparam int PosWidth   = 5;
   localparam int AddrWidth  = 5;
   localparam int DataWidth  = 32;
   localparam int IndexWidth = 3;

   typedef logic [TimeWidth-1:0] time_us_type;

   // register indexes, byte address is four times the index
   typedef enum logic [IndexWidth-1:0] {
      REG_HEADER_MIN = 3'd0,
      REG_HEADER_MAX = 3'd1,
      REG_ONE_MIN    = 3'd2,
      REG_ONE_MAX    = 3'd3,
      REG_ZERO_MIN   = 3'd4,
      REG_ZERO_MAX   = 3'd5,
      REG_GAP_MIN    = 3'd6,
      REG_GAP_MAX    = 3'd7
   } reg_index_type;

   // timing windows handed from the register block to the decoder
   typedef struct packed {
      time_us_type hdr_low;
      time_us_type hdr_high;
      time_us_type one_low;
      time_us_type one_high;
      time_us_type zero_low;
      time_us_type zero_high;
      time_us_type gap_low;
      time_us_type gap_high;
   } cfg_type;

   // inclusive window test, an inverted window never matches
   function automatic logic in_window(time_us_type v, time_us_type lo, time_us_type hi);
      return (v >= lo) && (v <= hi);
   endfunction

endpackage

`default_nettype wire

### hdl/ir_pulse_width_code_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_code_decoder
// pulse width ir code decoder: edge timestamps in, completed code words out
// ----------------------------------------------------------------------------
// usage
//   req channel carries one pin edge per request: a 16-bit microsecond
//   timestamp and the pin level after the edge. rsp channel carries one
//   completed code word, first received bit in bit 0. both use valid/ready.
//   csr is an apb port with eight 16-bit window bounds at 4-byte steps;
//   change them only while no request is in flight.
// timing
//   a request is registered on acceptance and decoded, once the result
//   register can take its output, by a single compare/add stage; its code
//   word passes the input register and then the result register to reach
//   rsp. one request per cycle is sustained while rsp is taken, the decode stage being the only per-edge work.
// stall
//   a held code word blocks the decode stage only; the input register still
//   takes one more request, then req_ready drops until rsp is taken.
// reset
//   synchronous, active high: decoder idle awaiting a header, code, previous
//   timestamp and last gap cleared, windows back to their default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_code_decoder
   import ir_pwcd_pkg::*;
#(
   parameter int CODE_BITS         = 12,
   parameter int PULSE_START_LEVEL = 0
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [TimeWidth-1:0] req_edge_time_us,
   input  wire logic                 req_pin_level,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [CodeWidth-1:0] rsp_received_code,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [DataWidth-1:0] csr_pwdata,
   output logic      [DataWidth-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type              cfg;
   logic                 in_valid_ff, in_valid_in;
   time_us_type          in_time_ff, in_time_in;
   logic                 in_level_ff, in_level_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CodeWidth-1:0] rsp_code_ff, rsp_code_in;
   logic                 fire;
   logic                 emit;
   logic [CodeWidth-1:0] code;

   // register block
   ir_pwcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // decode stage, fires when the result register can take its output
   assign fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);

   ir_pwcd_step #(
      .CODE_BITS         (CODE_BITS),
      .PULSE_START_LEVEL (PULSE_START_LEVEL)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .edge_time_us (in_time_ff),
      .pin_level    (in_level_ff),
      .cfg          (cfg),
      .emit         (emit),
      .code         (code)
   );

   // input register
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff && !fire;
      in_time_in  = in_time_ff;
      in_level_in = in_level_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_time_in  = req_edge_time_us;
         in_level_in = req_pin_level;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = code;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_received_code = rsp_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_time_ff  <= in_time_in;
      in_level_ff <= in_level_in;
      rsp_code_ff <= rsp_code_in;
   end

   // checks
`include "ir_pulse_width_code_decoder_macros.svh"

   `IRPW_ASSERT_RST(a_reset_empties, reset |=> !in_valid_ff && !rsp_valid_ff, "reset left a request or code word pending")
   `IRPW_ASSERT(a_emit_on_pulse_end, fire && emit |-> in_level_ff != 1'(PULSE_START_LEVEL), "code word emitted on a pulse start edge")
   `IRPW_ASSERT(a_accept_registers, req_valid && req_ready |=> in_valid_ff, "accepted request not held in the input register")
   `IRPW_ASSERT(a_emit_loads_rsp, fire && emit |=> rsp_valid_ff && rsp_code_ff == $past(code), "completed code word not presented")

endmodule

`default_nettype wire

### hdl/ir_pwcd_csr.sv
// ----------------------------------------------------------------------------
// ir_pwcd_csr
// apb register block holding the eight timing window bounds
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pwcd_csr
   import ir_pwcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [DataWidth-1:0] csr_pwdata,
   output logic      [DataWidth-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   time_us_type   wdata;
   time_us_type   rdata;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[AddrWidth-1:2]);
   assign wdata      = csr_pwdata[TimeWidth-1:0];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_HEADER_MIN: cfg_in.hdr_low   = wdata;
            REG_HEADER_MAX: cfg_in.hdr_high  = wdata;
            REG_ONE_MIN:    cfg_in.one_low   = wdata;
            REG_ONE_MAX:    cfg_in.one_high  = wdata;
            REG_ZERO_MIN:   cfg_in.zero_low  = wdata;
            REG_ZERO_MAX:   cfg_in.zero_high = wdata;
            REG_GAP_MIN:    cfg_in.gap_low   = wdata;
            REG_GAP_MAX:    cfg_in.gap_high  = wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // read back mux
   always_comb begin
      unique case (index)
         REG_HEADER_MIN: rdata = cfg_ff.hdr_low;
         REG_HEADER_MAX: rdata = cfg_ff.hdr_high;
         REG_ONE_MIN:    rdata = cfg_ff.one_low;
         REG_ONE_MAX:    rdata = cfg_ff.one_high;
         REG_ZERO_MIN:   rdata = cfg_ff.zero_low;
         REG_ZERO_MAX:   rdata = cfg_ff.zero_high;
         REG_GAP_MIN:    rdata = cfg_ff.gap_low;
         REG_GAP_MAX:    rdata = cfg_ff.gap_high;
         default:        rdata = '0;
      endcase
   end

   assign csr_prdata = {{(DataWidth-TimeWidth){1'b0}}, rdata};

   // window registers with their default timings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hdr_low   <= 16'd2200;
         cfg_ff.hdr_high  <= 16'd2600;
         cfg_ff.one_low   <= 16'd1000;
         cfg_ff.one_high  <= 16'd1400;
         cfg_ff.zero_low  <= 16'd400;
         cfg_ff.zero_high <= 16'd800;
         cfg_ff.gap_low   <= 16'd400;
         cfg_ff.gap_high  <= 16'd800;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ir_pwcd_step.sv
// ----------------------------------------------------------------------------
// ir_pwcd_step
// per-edge decode: interval, window checks, bit assembly and decoder state
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pwcd_step
   import ir_pwcd_pkg::*;
#(
   parameter int CODE_BITS         = 12,
   parameter int PULSE_START_LEVEL = 0
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire time_us_type          edge_time_us,
   input  wire logic                 pin_level,
   input  wire cfg_type              cfg,
   output logic                      emit,
   output logic      [CodeWidth-1:0] code
);

   localparam logic [PosWidth-1:0] LastPos    = PosWidth'(CODE_BITS);
   localparam logic                StartLevel = 1'(PULSE_START_LEVEL);

   logic [PosWidth-1:0]  bit_position_ff, bit_position_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   time_us_type          prev_time_ff, prev_time_in;
   time_us_type          last_gap_ff, last_gap_in;
   time_us_type          interval;
   logic [PosWidth-1:0]  slot;
   logic [CodeWidth-1:0] set_mask;
   logic                 hdr_ok, one_ok, zero_ok, gap_ok;

   // modular interval since the previous edge
   assign interval = edge_time_us - prev_time_ff;
   assign slot     = bit_position_ff - PosWidth'(1);

   assign hdr_ok  = in_window(interval, cfg.hdr_low, cfg.hdr_high);
   assign one_ok  = in_window(interval, cfg.one_low, cfg.one_high);
   assign zero_ok = in_window(interval, cfg.zero_low, cfg.zero_high);
   assign gap_ok  = in_window(last_gap_ff, cfg.gap_low, cfg.gap_high);

   // one-hot bit for the current slot, empty past the stored width
   always_comb begin
      for (int i = 0; i < CodeWidth; i++) begin
         set_mask[i] = (slot == PosWidth'(i));
      end
   end

   // next state for one edge
   always_comb begin
      bit_position_in = bit_position_ff;
      code_in         = code_ff;
      last_gap_in     = last_gap_ff;
      prev_time_in    = edge_time_us;
      emit            = 1'b0;
      priority if (pin_level == StartLevel) begin
         last_gap_in = interval;
      end else if (bit_position_ff == '0) begin
         if (hdr_ok) begin
            bit_position_in = PosWidth'(1);
            code_in         = '0;
         end
      end else if (!gap_ok) begin
         bit_position_in = '0;
      end else if (one_ok || zero_ok) begin
         if (one_ok) begin
            code_in = code_ff | set_mask;
         end
         if (bit_position_ff >= LastPos) begin
            bit_position_in = '0;
            emit            = 1'b1;
         end else begin
            bit_position_in = bit_position_ff + PosWidth'(1);
         end
      end else begin
         bit_position_in = '0;
      end
   end

   assign code = code_in;

   // decoder state, advanced once per edge
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff <= '0;
         code_ff         <= '0;
         prev_time_ff    <= '0;
         last_gap_ff     <= '0;
      end else if (fire) begin
         bit_position_ff <= bit_position_in;
         code_ff         <= code_in;
         prev_time_ff    <= prev_time_in;
         last_gap_ff     <= last_gap_in;
      end
   end

endmodule

`default_nettype wire
